// ===== design/dmc_pkg.sv =====
// ----------------------------------------------------------------------------
// dmc_pkg
// shared codes and helpers for the depth-first maze carver
// ----------------------------------------------------------------------------
`default_nettype none

package dmc_pkg;

  localparam logic [1:0] DIR_NORTH = 2'd0;
  localparam logic [1:0] DIR_EAST  = 2'd1;
  localparam logic [1:0] DIR_SOUTH = 2'd2;
  localparam logic [1:0] DIR_WEST  = 2'd3;

  localparam logic CMD_RESTART = 1'b0;
  localparam logic CMD_STEP    = 1'b1;

  localparam logic REG_NUM_COLS = 1'b0;
  localparam logic REG_NUM_ROWS = 1'b1;

  // remainder by three: base-4 digits sum to the same residue
  function automatic logic [1:0] mod3_16(input logic [15:0] v);
    logic [4:0] s;
    logic [2:0] t;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/dmc_nbr.sv =====
// ----------------------------------------------------------------------------
// dmc_nbr
// neighbour unit: coordinates, grid check and cell index for one direction
// ----------------------------------------------------------------------------
`default_nettype none

module dmc_nbr
  import dmc_pkg::*;
#(
  parameter int MAX_WIDTH  = 32,
  parameter int MAX_HEIGHT = 16
) (
  input  wire logic [$clog2(MAX_WIDTH)-1:0]                  x,
  input  wire logic [$clog2(MAX_HEIGHT)-1:0]                 y,
  input  wire logic [1:0]                                    dir,
  input  wire logic [$clog2(MAX_WIDTH + 64)-1:0]             used_w,
  input  wire logic [$clog2(MAX_HEIGHT + 32)-1:0]            used_h,
  output logic      [$clog2(MAX_WIDTH)-1:0]                  nx,
  output logic      [$clog2(MAX_HEIGHT)-1:0]                 ny,
  output logic                                               in_grid,
  output logic      [$clog2(MAX_WIDTH * MAX_HEIGHT)-1:0]     addr
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int YW  = $clog2(MAX_HEIGHT);
  localparam int XCW = $clog2(MAX_WIDTH + 64);
  localparam int YCW = $clog2(MAX_HEIGHT + 32);
  localparam int AW  = $clog2(MAX_WIDTH * MAX_HEIGHT);

  logic [XCW-1:0] xe;
  logic [YCW-1:0] ye;
  logic [XCW-1:0] nxe;
  logic [YCW-1:0] nye;

  assign xe = XCW'(x);
  assign ye = YCW'(y);

  always_comb begin
    nxe     = xe;
    nye     = ye;
    in_grid = 1'b0;
    case (dir)
      DIR_NORTH: begin
        nye     = ye - YCW'(1);
        in_grid = (y != '0) && (xe < used_w) && (nye < used_h);
      end
      DIR_EAST: begin
        nxe     = xe + XCW'(1);
        in_grid = (nxe < used_w) && (ye < used_h);
      end
      DIR_SOUTH: begin
        nye     = ye + YCW'(1);
        in_grid = (xe < used_w) && (nye < used_h);
      end
      DIR_WEST: begin
        nxe     = xe - XCW'(1);
        in_grid = (x != '0) && (nxe < used_w) && (ye < used_h);
      end
      default: begin
        in_grid = 1'b0;
      end
    endcase
  end

  assign nx   = nxe[XW-1:0];
  assign ny   = nye[YW-1:0];
  assign addr = AW'(ny) * AW'(MAX_WIDTH) + AW'(nx);

endmodule

`default_nettype wire

// ===== design/dfs_maze_carver.sv =====
// step: the beat runs through four visited-memory probes in one neighbour unit, then
//   choose and commit (or pop), then the result; no new beat is taken before it is registered
// step with an empty stack: no probes, the result is reported as finished
// restart: all MAX_WIDTH*MAX_HEIGHT visited entries cleared, one visited entry cleared per cycle
// reset: synchronous; stack empty, current cell (0,0), grid 22 x 11, no visited
//   clearing until the first restart
// ----------------------------------------------------------------------------
// dfs_maze_carver
// randomized depth-first maze carver with a backtrack stack in memory
// ----------------------------------------------------------------------------
`default_nettype none

module dfs_maze_carver
  import dmc_pkg::*;
#(
  parameter int MAX_WIDTH  = 32,
  parameter int MAX_HEIGHT = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // random_word
  input  wire logic        s_axis_tuser,   // command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // carved, backtracked, from_x[4:0], from_y[3:0], wall_direction[1:0],
  // to_x[4:0], to_y[3:0], finished, zero pad
  output logic      [23:0] m_axis_tdata,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [5:0]  cfg_data
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int XCW   = $clog2(MAX_WIDTH + 64);
  localparam int YCW   = $clog2(MAX_HEIGHT + 32);
  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam int SW    = XW + YW;

  typedef enum logic [2:0] {
    IDLE, CLEAR, PROBE, CHOOSE, COMMIT, POP, FINISH
  } state_t;

  state_t        state;
  logic [2:0]    pc;
  logic [3:0]    cand;
  logic          ing_d;
  logic [15:0]   rnd;
  logic [XW-1:0] cur_x;
  logic [YW-1:0] cur_y;
  logic [XW-1:0] from_x;
  logic [YW-1:0] from_y;
  logic [AW:0]   count;
  logic [AW-1:0] clr_idx;
  logic [1:0]    dir_sel;
  logic          res_carved;
  logic          res_back;
  logic [5:0]    num_cols;
  logic [4:0]    num_rows;
  logic          out_carved;
  logic          out_fin;
  logic [23:0]   out_data;

  logic [XCW-1:0] used_w;
  logic [YCW-1:0] used_h;
  logic [1:0]     nbr_dir;
  logic [XW-1:0]  nbr_x;
  logic [YW-1:0]  nbr_y;
  logic           nbr_in_grid;
  logic [AW-1:0]  nbr_addr;

  logic           vis_mem [CELLS];
  logic           vis_we;
  logic [AW-1:0]  vis_waddr;
  logic           vis_wdata;
  logic           vis_rdata;

  logic [SW-1:0]  stk_mem [CELLS];
  logic           stk_we;
  logic [AW-1:0]  stk_waddr;
  logic [SW-1:0]  stk_wdata;
  logic [AW:0]    cnt_m1;
  logic [SW-1:0]  stk_rdata;

  logic [2:0]     n_cand;
  logic [1:0]     k_sel;
  logic [1:0]     pick;
  logic           accept;
  logic           out_free;
  logic [XW+4:0]  fx_ext;
  logic [YW+3:0]  fy_ext;
  logic [XW+4:0]  tx_ext;
  logic [YW+3:0]  ty_ext;

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == IDLE);
  assign m_axis_tdata  = out_data;

  // saturate grid size to 2..MAX
  always_comb begin
    if (XCW'(num_cols) < XCW'(2)) begin
      used_w = XCW'(2);
    end else if (XCW'(num_cols) > XCW'(MAX_WIDTH)) begin
      used_w = XCW'(MAX_WIDTH);
    end else begin
      used_w = XCW'(num_cols);
    end
    if (YCW'(num_rows) < YCW'(2)) begin
      used_h = YCW'(2);
    end else if (YCW'(num_rows) > YCW'(MAX_HEIGHT)) begin
      used_h = YCW'(MAX_HEIGHT);
    end else begin
      used_h = YCW'(num_rows);
    end
  end

  assign nbr_dir = (state == COMMIT) ? dir_sel : pc[1:0];

  dmc_nbr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_nbr (
    .x       (cur_x),
    .y       (cur_y),
    .dir     (nbr_dir),
    .used_w  (used_w),
    .used_h  (used_h),
    .nx      (nbr_x),
    .ny      (nbr_y),
    .in_grid (nbr_in_grid),
    .addr    (nbr_addr)
  );

  // candidate count and selection
  always_comb begin
    logic [2:0] seen;
    logic       found;
    seen   = '0;
    found  = 1'b0;
    pick   = DIR_NORTH;
    n_cand = 3'($countones(cand));
    case (n_cand)
      3'd2:    k_sel = {1'b0, rnd[0]};
      3'd3:    k_sel = mod3_16(rnd);
      3'd4:    k_sel = rnd[1:0];
      default: k_sel = 2'd0;
    endcase
    for (int d = 0; d < 4; d++) begin
      if (cand[d] && !found && (seen == 3'(k_sel))) begin
        pick  = 2'(d);
        found = 1'b1;
      end
      if (cand[d]) begin
        seen = seen + 3'd1;
      end
    end
  end

  // memory ports
  always_comb begin
    vis_we    = 1'b0;
    vis_waddr = nbr_addr;
    vis_wdata = 1'b1;
    if (state == CLEAR) begin
      vis_we    = 1'b1;
      vis_waddr = clr_idx;
      vis_wdata = (clr_idx == '0);
    end else if (state == COMMIT) begin
      vis_we = 1'b1;
    end
  end

  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = count[AW-1:0];
    stk_wdata = {cur_y, cur_x};
    if (accept && (s_axis_tuser == CMD_RESTART)) begin
      stk_we    = 1'b1;
      stk_waddr = '0;
      stk_wdata = '0;
    end else if ((state == COMMIT) && (count < (AW+1)'(CELLS))) begin
      stk_we = 1'b1;
    end
  end

  assign cnt_m1 = count - (AW+1)'(1);

  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    vis_rdata <= vis_mem[nbr_addr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rdata <= stk_mem[cnt_m1[AW-1:0]];
  end

  assign fx_ext = (XW+5)'(from_x);
  assign fy_ext = (YW+4)'(from_y);
  assign tx_ext = (XW+5)'(cur_x);
  assign ty_ext = (YW+4)'(cur_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      pc            <= '0;
      count         <= '0;
      cur_x         <= '0;
      cur_y         <= '0;
      clr_idx       <= '0;
      num_cols      <= 6'd22;
      num_rows      <= 5'd11;
      m_axis_tvalid <= 1'b0;
      out_carved    <= 1'b0;
      out_fin       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NUM_COLS: num_cols <= cfg_data;
          REG_NUM_ROWS: num_rows <= cfg_data[4:0];
          default:      num_cols <= num_cols;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready && (state != FINISH)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            rnd        <= s_axis_tdata;
            from_x     <= cur_x;
            from_y     <= cur_y;
            res_carved <= 1'b0;
            res_back   <= 1'b0;
            dir_sel    <= DIR_NORTH;
            pc         <= '0;
            cand       <= '0;
            if (s_axis_tuser == CMD_RESTART) begin
              count   <= (AW+1)'(1);
              cur_x   <= '0;
              cur_y   <= '0;
              clr_idx <= '0;
              state   <= CLEAR;
            end else if (count == '0) begin
              state <= FINISH;
            end else begin
              state <= PROBE;
            end
          end
        end
        CLEAR: begin
          clr_idx <= clr_idx + AW'(1);
          if (clr_idx == AW'(CELLS - 1)) begin
            state <= FINISH;
          end
        end
        PROBE: begin
          ing_d <= nbr_in_grid;
          if (pc != 3'd0) begin
            cand[2'(pc - 3'd1)] <= ing_d && !vis_rdata;
          end
          pc <= pc + 3'd1;
          if (pc == 3'd4) begin
            state <= CHOOSE;
          end
        end
        CHOOSE: begin
          if (n_cand != 3'd0) begin
            dir_sel <= pick;
            state   <= COMMIT;
          end else begin
            count <= cnt_m1;
            state <= POP;
          end
        end
        COMMIT: begin
          if (count < (AW+1)'(CELLS)) begin
            count <= count + (AW+1)'(1);
          end
          cur_x      <= nbr_x;
          cur_y      <= nbr_y;
          res_carved <= 1'b1;
          state      <= FINISH;
        end
        POP: begin
          cur_x    <= stk_rdata[XW-1:0];
          cur_y    <= stk_rdata[SW-1:XW];
          res_back <= 1'b1;
          state    <= FINISH;
        end
        FINISH: begin
          if (out_free) begin
            out_data <= {1'b0, (count == '0), ty_ext[3:0], tx_ext[4:0], dir_sel,
                         fy_ext[3:0], fx_ext[4:0], res_back, res_carved};
            out_carved    <= res_carved;
            out_fin       <= (count == '0);
            m_axis_tvalid <= 1'b1;
            state         <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(CELLS))
    else $error("stack count beyond depth");

  a_commit_in_grid: assert property (@(posedge clk) disable iff (rst)
    (state == COMMIT) |-> nbr_in_grid)
    else $error("carve toward a cell outside the grid");

  a_carve_not_done: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(out_carved && out_fin))
    else $error("carve reported with empty stack");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    ((state == CHOOSE) && (n_cand == 3'd0)) |-> (count != '0))
    else $error("pop from empty stack");
`endif

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks dfs_maze_carver against a cycle-free model of the randomized
// depth-first search: every taken command beat is run through the model
// and each result beat is compared field by field, in order, with the
// oldest prediction; sender bursts and receiver stalls are randomized
// ----------------------------------------------------------------------------

module testbench;
  import dmc_pkg::*;

  localparam int COLS_MAX = 32;
  localparam int ROWS_MAX = 16;
  localparam int CELL_TOTAL = COLS_MAX * ROWS_MAX;
  localparam int STIM_TARGET = 1150;

  typedef struct packed {
    logic        cmd;
    logic [15:0] word;
  } maze_cmd_t;

  // packed so that carved lands in bit 0, as on m_axis_tdata
  typedef struct packed {
    logic       finished;
    logic [3:0] to_y;
    logic [4:0] to_x;
    logic [1:0] wall_dir;
    logic [3:0] from_y;
    logic [4:0] from_x;
    logic       backtracked;
    logic       carved;
  } carve_move_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [5:0]  cfg_data = '0;

  always #1 clk = ~clk;

  dfs_maze_carver dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // model state
  logic       visited [0:CELL_TOTAL-1];
  logic [8:0] trail [0:CELL_TOTAL-1];
  int         trail_depth;
  logic [4:0] cur_x;
  logic [3:0] cur_y;
  logic [5:0] width_reg;
  logic [4:0] height_reg;

  maze_cmd_t   cmd_backlog [$];
  carve_move_t expected_moves [$];
  int          errors = 0;

  function automatic int used_span(int value, int limit);
    if (value < 2) return 2;
    if (value > limit) return limit;
    return value;
  endfunction

  function automatic logic unvisited(int x, int y, int w, int h);
    if (x >= w || y >= h) return 1'b0;
    return !visited[y * COLS_MAX + x];
  endfunction

  function automatic carve_move_t carve_step(maze_cmd_t c);
    carve_move_t mv;
    logic [1:0]  options [4];
    int          n, w, h, x, y, nx, ny, top;
    mv = '0;
    mv.from_x = cur_x;
    mv.from_y = cur_y;
    if (c.cmd == CMD_RESTART) begin
      visited = '{default: 1'b0};
      visited[0] = 1'b1;
      trail[0] = '0;
      trail_depth = 1;
      cur_x = '0;
      cur_y = '0;
    end else if (trail_depth == 0) begin
      mv.finished = 1'b1;
    end else begin
      w = used_span(width_reg, COLS_MAX);
      h = used_span(height_reg, ROWS_MAX);
      x = cur_x;
      y = cur_y;
      n = 0;
      if (y > 0 && unvisited(x, y - 1, w, h)) begin
        options[n] = DIR_NORTH;
        n++;
      end
      if (unvisited(x + 1, y, w, h)) begin
        options[n] = DIR_EAST;
        n++;
      end
      if (unvisited(x, y + 1, w, h)) begin
        options[n] = DIR_SOUTH;
        n++;
      end
      if (x > 0 && unvisited(x - 1, y, w, h)) begin
        options[n] = DIR_WEST;
        n++;
      end
      if (n > 0) begin
        mv.wall_dir = options[int'(c.word) % n];
        nx = x;
        ny = y;
        case (mv.wall_dir)
          DIR_NORTH: ny = y - 1;
          DIR_EAST:  nx = x + 1;
          DIR_SOUTH: ny = y + 1;
          default:   nx = x - 1;
        endcase
        visited[ny * COLS_MAX + nx] = 1'b1;
        if (trail_depth < CELL_TOTAL) begin
          trail[trail_depth] = 9'(y * COLS_MAX + x);
          trail_depth++;
        end
        cur_x = 5'(nx);
        cur_y = 4'(ny);
        mv.carved = 1'b1;
      end else begin
        trail_depth--;
        top = trail[trail_depth];
        cur_x = 5'(top % COLS_MAX);
        cur_y = 4'(top / COLS_MAX);
        mv.backtracked = 1'b1;
      end
      mv.finished = (trail_depth == 0);
    end
    mv.to_x = cur_x;
    mv.to_y = cur_y;
    return mv;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      width_reg <= 6'd22;
      height_reg <= 5'd11;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_COLS: width_reg <= cfg_data;
        REG_NUM_ROWS: height_reg <= 5'(cfg_data);
      endcase
    end
  end

  // command driver
  maze_cmd_t cur_cmd = '0;
  logic      offering = 1'b0;
  int        burst_left = 0;
  int        gap_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      visited = '{default: 1'b0};
      trail_depth = 0;
      cur_x = '0;
      cur_y = '0;
      offering = 1'b0;
      s_axis_tvalid <= 1'b0;
    end else begin
      if (offering && s_axis_tready) begin
        expected_moves.push_back(carve_step(cur_cmd));
        offering = 1'b0;
      end
      if (!offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_backlog.size() > 0) begin
          cur_cmd = cmd_backlog.pop_front();
          offering = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      s_axis_tvalid <= offering;
      s_axis_tdata <= cur_cmd.word;
      s_axis_tuser <= cur_cmd.cmd;
    end
  end

  // result monitor
  int   moves_seen = 0;
  int   hold_left = 0;
  int   mode = 0;
  int   mode_left = 0;
  logic ready_next;

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_move(logic [23:0] beat);
    carve_move_t got, want;
    got = carve_move_t'(beat[22:0]);
    if (expected_moves.size() == 0) begin
      $display("%0t: result beat with none expected, expected none actual %h",
               $time, beat);
      errors++;
    end else begin
      want = expected_moves.pop_front();
      compare_field("carved", want.carved, got.carved);
      compare_field("backtracked", want.backtracked, got.backtracked);
      compare_field("from_x", want.from_x, got.from_x);
      compare_field("from_y", want.from_y, got.from_y);
      compare_field("wall_direction", want.wall_dir, got.wall_dir);
      compare_field("to_x", want.to_x, got.to_x);
      compare_field("to_y", want.to_y, got.to_y);
      compare_field("finished", want.finished, got.finished);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_move(m_axis_tdata);
        moves_seen++;
        // long hold-off so the block backs up into its input
        if (moves_seen % 500 == 120) hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(8, 80);
        end
        mode_left--;
        case (mode)
          0, 1:    ready_next = 1'b1;
          2:       ready_next = 1'($urandom_range(0, 1));
          default: ready_next = ($urandom_range(0, 4) == 0);
        endcase
      end
      m_axis_tready <= ready_next;
    end
  end

  // stimulus
  int queued = 0;

  task automatic queue_cmd(logic cmd, logic [15:0] word);
    maze_cmd_t c;
    c.cmd = cmd;
    c.word = word;
    cmd_backlog.push_back(c);
    queued++;
  endtask

  task automatic queue_steps(int count);
    for (int i = 0; i < count; i++) queue_cmd(CMD_STEP, 16'($urandom_range(0, 65535)));
  endtask

  task automatic wait_idle;
    do @(negedge clk);
    while (cmd_backlog.size() != 0 || offering || expected_moves.size() != 0);
    repeat (12) @(negedge clk);
  endtask

  task automatic set_grid(int w, int h);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_NUM_COLS;
    cfg_data <= 6'(w);
    @(posedge clk);
    cfg_index <= REG_NUM_ROWS;
    cfg_data <= 6'(h);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic int pick_odd_size(int limit);
    if ($urandom_range(0, 1) == 0) return $urandom_range(0, 1);
    return $urandom_range(limit + 1, (limit == COLS_MAX) ? 63 : 31);
  endfunction

  initial begin
    int kind, pick, w, h, cells, steps;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // steps before any restart see an empty stack
    queue_cmd(CMD_STEP, 16'h0000);
    queue_cmd(CMD_STEP, 16'hFFFF);
    queue_cmd(CMD_RESTART, 16'hFFFF);
    queue_cmd(CMD_STEP, 16'h0000);
    queue_cmd(CMD_STEP, 16'hFFFF);
    queue_cmd(CMD_STEP, 16'h5555);
    queue_cmd(CMD_STEP, 16'hAAAA);
    queue_cmd(CMD_STEP, 16'h0001);
    queue_cmd(CMD_STEP, 16'h0002);
    queue_cmd(CMD_STEP, 16'h0003);
    // restart away from the origin
    queue_cmd(CMD_RESTART, 16'h1234);
    wait_idle();

    // smallest grid carried to completion and past it
    set_grid(2, 2);
    queue_cmd(CMD_RESTART, 16'h0000);
    queue_steps(9);
    wait_idle();

    while (queued < STIM_TARGET) begin
      pick = $urandom_range(0, 15);
      case (pick)
        0: begin
          w = pick_odd_size(COLS_MAX);
          h = pick_odd_size(ROWS_MAX);
        end
        1: begin
          w = COLS_MAX;
          h = 2;
        end
        2: begin
          w = 2;
          h = ROWS_MAX;
        end
        3: begin
          w = COLS_MAX;
          h = ROWS_MAX;
        end
        default: begin
          w = $urandom_range(2, 8);
          h = $urandom_range(2, 6);
        end
      endcase
      set_grid(w, h);
      cells = used_span(w, COLS_MAX) * used_span(h, ROWS_MAX);
      steps = 2 * cells - 1 + $urandom_range(0, 3);
      if (steps > 160) steps = $urandom_range(60, 160);
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        queue_cmd(CMD_RESTART, 16'($urandom_range(0, 65535)));
        queue_steps(steps);
      end else if (kind == 7) begin
        // grid resized under a search in progress
        queue_steps($urandom_range(5, 30));
      end else if (kind == 8) begin
        for (int i = $urandom_range(10, 30); i > 0; i--) begin
          queue_cmd(($urandom_range(0, 5) == 0) ? CMD_RESTART : CMD_STEP,
                    16'($urandom_range(0, 65535)));
        end
      end else begin
        queue_cmd(CMD_RESTART, 16'($urandom_range(0, 65535)));
        queue_steps($urandom_range(1, (steps < cells) ? steps : cells));
      end
      wait_idle();
    end

    if (errors == 0 && expected_moves.size() == 0) begin
      $display("dfs_maze_carver verification clean");
    end else begin
      $display("dfs_maze_carver verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("dfs_maze_carver verification failed");
    $finish;
  end

endmodule

// ===== dfs_maze_carver.f =====
design/dmc_pkg.sv
design/dmc_nbr.sv
design/dfs_maze_carver.sv
sim/testbench.sv
